/* design/tep_pkg.sv */
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types and constants of the terminal escape parser: parser states,
// event kinds, the parser context and the event record.
// ----------------------------------------------------------------------------
package tep_pkg;

    localparam int TEP_MAX_PARAMS   = 16;
    localparam int TEP_OSC_CAPACITY = 256;
    // most events one byte may cause
    localparam int MAX_RESULTS      = 16;

    localparam logic [29:0] PARAM_LIMIT    = 30'd100000000;
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    localparam logic [7:0] BYTE_BEL    = 8'h07;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_DEL    = 8'h7F;

    localparam logic [2:0] KIND_PRINT     = 3'd0;
    localparam logic [2:0] KIND_CONTROL   = 3'd1;
    localparam logic [2:0] KIND_ESC_FINAL = 3'd2;
    localparam logic [2:0] KIND_CSI_PARAM = 3'd3;
    localparam logic [2:0] KIND_OSC_END   = 3'd4;

    typedef enum logic [3:0] {
        PS_GROUND,
        PS_ESC,
        PS_CSI_ENTRY,
        PS_CSI_PARAM,
        PS_CSI_MID,
        PS_CSI_IGNORE,
        PS_OSC,
        PS_OSC_ESC,
        PS_STR_IGNORE,
        PS_STR_ESC
    } parse_state_t;

    typedef struct packed {
        parse_state_t state;
        logic [1:0]   utf_need;
        logic [1:0]   utf_seen;
        logic [20:0]  utf_acc;
        logic [7:0]   prefix;
        logic [7:0]   middle;
        logic [29:0]  cur_param;
    } psr_ctx_t;

    localparam psr_ctx_t CTX_RESET = '{
        state:     PS_GROUND,
        utf_need:  2'd0,
        utf_seen:  2'd0,
        utf_acc:   21'd0,
        prefix:    8'd0,
        middle:    8'd0,
        cur_param: 30'd0
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] code;
        logic [7:0]  private_marker;
        logic [7:0]  intermediate_byte;
        logic [3:0]  param_index;
        logic [29:0] param_value;
        logic [4:0]  param_count;
        logic [7:0]  string_length;
    } tep_event_t;

    typedef struct packed {
        logic [1:0] n_events;
        logic       dispatch;
        logic       mem_we;
        tep_event_t ev0;
        tep_event_t ev1;
    } step_out_t;

endpackage

/* design/tep_byte_if.sv */
// ----------------------------------------------------------------------------
// tep_byte_if
// Byte stream channel into the parser: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface tep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;

    modport source (output valid, output byte_req, input ready);
    modport sink   (input valid, input byte_req, output ready);
endinterface

/* design/tep_event_if.sv */
// ----------------------------------------------------------------------------
// tep_event_if
// Event channel out of the parser: valid, ready and one event record.
// ----------------------------------------------------------------------------
interface tep_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [20:0] code;
    logic [7:0]  private_marker;
    logic [7:0]  intermediate_byte;
    logic [3:0]  param_index;
    logic [29:0] param_value;
    logic [4:0]  param_count;
    logic [7:0]  string_length;
    logic        last;

    modport source (
        output valid, output kind, output code, output private_marker,
        output intermediate_byte, output param_index, output param_value,
        output param_count, output string_length, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input code, input private_marker,
        input intermediate_byte, input param_index, input param_value,
        input param_count, input string_length, input last,
        output ready
    );
endinterface

/* design/tep_step.sv */
// ----------------------------------------------------------------------------
// tep_step
// Next-state logic for one stream byte: utf-8 decode, escape and csi/osc
// parsing, up to two simple events and the csi dispatch request.
// ----------------------------------------------------------------------------
module tep_step import tep_pkg::*; #(
    parameter int MAX_PARAMS   = TEP_MAX_PARAMS,
    parameter int OSC_CAPACITY = TEP_OSC_CAPACITY
) (
    input  logic [7:0]                        byte_req,
    input  psr_ctx_t                          ctx,
    input  logic [$clog2(MAX_PARAMS+1)-1:0]   total,
    input  logic [$clog2(OSC_CAPACITY)-1:0]   osc_len,
    output psr_ctx_t                          ctx_next,
    output logic [$clog2(MAX_PARAMS+1)-1:0]   total_next,
    output logic [$clog2(OSC_CAPACITY)-1:0]   osc_len_next,
    output logic [((MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1)-1:0] mem_waddr,
    output step_out_t                         res
);

    localparam int TOT_W = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int OSC_W = $clog2(OSC_CAPACITY);

    typedef struct packed {
        logic        emit;
        logic [20:0] code;
        logic        start;
        logic [1:0]  need;
        logic [20:0] acc;
    } fresh_t;

    // decode of a byte in ground with no utf-8 sequence pending
    function automatic fresh_t ground_fresh(input logic [7:0] b);
        fresh_t f;
        f = '0;
        if (b[7] == 1'b0) begin
            f.emit = (b != BYTE_DEL);
            f.code = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            f.start = 1'b1;
            f.need  = 2'd1;
            f.acc   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            f.start = 1'b1;
            f.need  = 2'd2;
            f.acc   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            f.start = 1'b1;
            f.need  = 2'd3;
            f.acc   = {18'd0, b[2:0]};
        end else begin
            f.emit = 1'b1;
            f.code = CP_REPLACEMENT;
        end
        return f;
    endfunction

    function automatic tep_event_t simple_event(input logic [2:0] k, input logic [20:0] c);
        tep_event_t ev;
        ev      = '0;
        ev.kind = k;
        ev.code = c;
        return ev;
    endfunction

    fresh_t      fr;
    logic        is_c0;
    logic        is_final;
    logic [20:0] acc_shift;
    logic [1:0]  seen_inc;
    logic [TOT_W-1:0] t1;

    assign fr        = ground_fresh(byte_req);
    assign is_c0     = (byte_req < 8'h20) && (ctx.state != PS_OSC)
                       && (ctx.state != PS_STR_IGNORE);
    assign is_final  = (byte_req >= 8'h40) && (byte_req <= 8'h7E);
    assign acc_shift = {ctx.utf_acc[14:0], byte_req[5:0]};
    assign seen_inc  = ctx.utf_seen + 2'd1;
    assign t1        = (total == '0) ? TOT_W'(1) : total;

    always_comb begin
        ctx_next     = ctx;
        total_next   = total;
        osc_len_next = osc_len;
        mem_waddr    = '0;
        res          = '0;

        if (is_c0) begin
            if (byte_req == BYTE_ESC) begin
                ctx_next.state     = PS_ESC;
                ctx_next.prefix    = 8'd0;
                ctx_next.middle    = 8'd0;
                ctx_next.cur_param = 30'd0;
                ctx_next.utf_need  = 2'd0;
                total_next         = '0;
            end else begin
                res.n_events = 2'd1;
                res.ev0      = simple_event(KIND_CONTROL, {13'd0, byte_req});
            end
        end else begin
            unique case (ctx.state)
                PS_GROUND: begin
                    if (ctx.utf_need != 2'd0) begin
                        if (byte_req[7:6] != 2'b10) begin
                            // broken sequence: replacement, then the byte as a new lead
                            res.ev0           = simple_event(KIND_PRINT, CP_REPLACEMENT);
                            res.ev1           = simple_event(KIND_PRINT, fr.code);
                            res.n_events      = fr.emit ? 2'd2 : 2'd1;
                            ctx_next.utf_need = fr.start ? fr.need : 2'd0;
                            if (fr.start) begin
                                ctx_next.utf_seen = 2'd0;
                                ctx_next.utf_acc  = fr.acc;
                            end
                        end else begin
                            ctx_next.utf_acc  = acc_shift;
                            ctx_next.utf_seen = seen_inc;
                            if (seen_inc == ctx.utf_need) begin
                                ctx_next.utf_need = 2'd0;
                                res.n_events      = 2'd1;
                                res.ev0           = simple_event(KIND_PRINT, acc_shift);
                            end
                        end
                    end else begin
                        res.ev0      = simple_event(KIND_PRINT, fr.code);
                        res.n_events = fr.emit ? 2'd1 : 2'd0;
                        if (fr.start) begin
                            ctx_next.utf_need = fr.need;
                            ctx_next.utf_seen = 2'd0;
                            ctx_next.utf_acc  = fr.acc;
                        end
                    end
                end
                PS_ESC: begin
                    if (byte_req == 8'h5B) begin
                        ctx_next.state     = PS_CSI_ENTRY;
                        ctx_next.prefix    = 8'd0;
                        ctx_next.middle    = 8'd0;
                        ctx_next.cur_param = 30'd0;
                        total_next         = '0;
                    end else if (byte_req == 8'h5D) begin
                        osc_len_next   = '0;
                        ctx_next.state = PS_OSC;
                    end else if ((byte_req == 8'h50) || (byte_req == 8'h58)
                                 || (byte_req == 8'h5E) || (byte_req == 8'h5F)) begin
                        ctx_next.state = PS_STR_IGNORE;
                    end else if ((byte_req >= 8'h28) && (byte_req <= 8'h2B)) begin
                        // charset designator: swallow the next byte
                        ctx_next.middle = byte_req;
                    end else if (ctx.middle != 8'd0) begin
                        ctx_next.middle = 8'd0;
                        ctx_next.state  = PS_GROUND;
                    end else begin
                        res.n_events   = 2'd1;
                        res.ev0        = simple_event(KIND_ESC_FINAL, {13'd0, byte_req});
                        ctx_next.state = PS_GROUND;
                    end
                end
                PS_CSI_ENTRY, PS_CSI_PARAM: begin
                    if ((byte_req >= 8'h30) && (byte_req <= 8'h39)) begin
                        total_next     = t1;
                        ctx_next.state = PS_CSI_PARAM;
                        if (ctx.cur_param < PARAM_LIMIT) begin
                            ctx_next.cur_param = {ctx.cur_param[26:0], 3'b000}
                                               + {ctx.cur_param[28:0], 1'b0}
                                               + {26'd0, byte_req[3:0]};
                        end
                    end else if ((byte_req == 8'h3B) || (byte_req == 8'h3A)) begin
                        ctx_next.state = PS_CSI_PARAM;
                        if (t1 < TOT_W'(MAX_PARAMS)) begin
                            // current parameter is done: park it in the store
                            res.mem_we         = 1'b1;
                            mem_waddr          = IDX_W'(t1 - TOT_W'(1));
                            ctx_next.cur_param = 30'd0;
                            total_next         = t1 + TOT_W'(1);
                        end else begin
                            total_next = t1;
                        end
                    end else if ((byte_req >= 8'h3C) && (byte_req <= 8'h3F)) begin
                        ctx_next.prefix = byte_req;
                        ctx_next.state  = PS_CSI_PARAM;
                    end else if ((byte_req >= 8'h20) && (byte_req <= 8'h2F)) begin
                        ctx_next.middle = byte_req;
                        ctx_next.state  = PS_CSI_MID;
                    end else if (is_final) begin
                        res.dispatch   = 1'b1;
                        ctx_next.state = PS_GROUND;
                    end else begin
                        ctx_next.state = PS_CSI_IGNORE;
                    end
                end
                PS_CSI_MID: begin
                    if (is_final) begin
                        res.dispatch   = 1'b1;
                        ctx_next.state = PS_GROUND;
                    end else if (byte_req > 8'h2F) begin
                        ctx_next.state = PS_CSI_IGNORE;
                    end
                end
                PS_CSI_IGNORE: begin
                    if (is_final) begin
                        ctx_next.state = PS_GROUND;
                    end
                end
                PS_OSC: begin
                    if (byte_req == BYTE_BEL) begin
                        res.n_events             = 2'd1;
                        res.ev0                  = simple_event(KIND_OSC_END, {13'd0, BYTE_BEL});
                        res.ev0.string_length    = 8'(osc_len);
                        ctx_next.state           = PS_GROUND;
                    end else if (byte_req == BYTE_ESC) begin
                        ctx_next.state = PS_OSC_ESC;
                    end else if (osc_len < OSC_W'(OSC_CAPACITY - 1)) begin
                        osc_len_next = osc_len + OSC_W'(1);
                    end
                end
                PS_OSC_ESC: begin
                    res.ev0               = simple_event(KIND_OSC_END, {13'd0, BYTE_ESC});
                    res.ev0.string_length = 8'(osc_len);
                    res.ev1               = simple_event(KIND_PRINT, fr.code);
                    res.n_events          = 2'd1;
                    ctx_next.state        = PS_GROUND;
                    if (byte_req != BYTE_BSLASH) begin
                        if (fr.emit) begin
                            res.n_events = 2'd2;
                        end
                        if (fr.start) begin
                            ctx_next.utf_need = fr.need;
                            ctx_next.utf_seen = 2'd0;
                            ctx_next.utf_acc  = fr.acc;
                        end
                    end
                end
                PS_STR_IGNORE: begin
                    if (byte_req == BYTE_ESC) begin
                        ctx_next.state = PS_STR_ESC;
                    end
                end
                PS_STR_ESC: begin
                    ctx_next.state = PS_GROUND;
                    res.ev0        = simple_event(KIND_PRINT, fr.code);
                    if (byte_req != BYTE_BSLASH) begin
                        res.n_events = fr.emit ? 2'd1 : 2'd0;
                        if (fr.start) begin
                            ctx_next.utf_need = fr.need;
                            ctx_next.utf_seen = 2'd0;
                            ctx_next.utf_acc  = fr.acc;
                        end
                    end
                end
                default: begin
                    ctx_next.state = PS_GROUND;
                end
            endcase
        end
    end

endmodule

/* design/terminal_escape_parser_unit.sv */
// ----------------------------------------------------------------------------
// terminal_escape_parser_unit
// Terminal output byte parser: utf-8 decode, c0 controls, escape finals,
// osc string ends and csi parameter events.
//
//   channel  dir  handshake      payload
//   stream   in   valid/ready    byte_req
//   events   out  valid/ready    kind, code, private_marker, intermediate_byte,
//                                param_index, param_value, param_count,
//                                string_length, last
//
// one byte per cycle while the output is free, when the byte gives at most one event
// a byte that gives two events (osc end or replacement plus a decoded byte)
//   holds stream ready low until its second event enters the output register
// a csi final holds stream ready low while its events go out; the parameter store
//   gives one entry per cycle while the output is free, via its registered read port
// events leave through an output register, so the next byte can be taken in the
//   same cycle as the last event leaves; no clearing pass after reset
// ----------------------------------------------------------------------------
module terminal_escape_parser_unit import tep_pkg::*; #(
    parameter int MAX_PARAMS   = TEP_MAX_PARAMS,
    parameter int OSC_CAPACITY = TEP_OSC_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    tep_byte_if.sink    stream,
    tep_event_if.source events
);

    localparam int TOT_W     = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int OSC_W     = $clog2(OSC_CAPACITY);
    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int RES_CAP   = (MAX_PARAMS < MAX_RESULTS) ? MAX_PARAMS : MAX_RESULTS;

    typedef enum logic [1:0] {
        CTL_RUN,
        CTL_SECOND,
        CTL_DISPATCH
    } ctl_state_t;

    ctl_state_t       ctl_reg, ctl_next;
    psr_ctx_t         ctx_reg, ctx_next, step_ctx;
    logic [TOT_W-1:0] total_reg, total_next, step_total;
    logic [OSC_W-1:0] osc_len_reg, osc_len_next, step_osc;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next, step_waddr;
    logic             out_valid_reg, out_valid_next;
    tep_event_t       out_ev_reg, sec_ev_reg, load_ev;
    logic             out_last_reg, load_last, load_out, load_sec;
    logic [7:0]       final_reg;
    logic [29:0]      mem_q_reg;
    logic [29:0]      param_mem [MEM_DEPTH];
    step_out_t        step;

    logic             accept;
    logic             slot_free;
    logic [TOT_W-1:0] emit_last_idx;
    logic             emit_is_last;
    logic             emit_is_cur;
    tep_event_t       csi_ev;

    tep_step #(
        .MAX_PARAMS   (MAX_PARAMS),
        .OSC_CAPACITY (OSC_CAPACITY)
    ) u_step (
        .byte_req     (stream.byte_req),
        .ctx          (ctx_reg),
        .total        (total_reg),
        .osc_len      (osc_len_reg),
        .ctx_next     (step_ctx),
        .total_next   (step_total),
        .osc_len_next (step_osc),
        .mem_waddr    (step_waddr),
        .res          (step)
    );

    assign slot_free    = !out_valid_reg || events.ready;
    assign stream.ready = (ctl_reg == CTL_RUN) && slot_free;
    assign accept       = stream.valid && stream.ready;

    // last event index of a csi dispatch; no parameters still gives one event
    assign emit_last_idx = (total_reg == '0) ? '0
                         : ((total_reg > TOT_W'(RES_CAP)) ? TOT_W'(RES_CAP) : total_reg)
                           - TOT_W'(1);
    assign emit_is_last  = (TOT_W'(emit_idx_reg) == emit_last_idx);
    // the open parameter lives in the context, earlier ones in the store
    assign emit_is_cur   = (total_reg == '0)
                         || (TOT_W'(emit_idx_reg) == total_reg - TOT_W'(1));

    always_comb begin
        csi_ev                   = '0;
        csi_ev.kind              = KIND_CSI_PARAM;
        csi_ev.code              = {13'd0, final_reg};
        csi_ev.private_marker    = ctx_reg.prefix;
        csi_ev.intermediate_byte = ctx_reg.middle;
        csi_ev.param_index       = 4'(emit_idx_reg);
        csi_ev.param_value       = emit_is_cur ? ctx_reg.cur_param : mem_q_reg;
        csi_ev.param_count       = 5'(total_reg);
    end

    always_comb begin
        ctl_next       = ctl_reg;
        ctx_next       = ctx_reg;
        total_next     = total_reg;
        osc_len_next   = osc_len_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !events.ready;
        load_out       = 1'b0;
        load_sec       = 1'b0;
        load_ev        = step.ev0;
        load_last      = 1'b0;

        unique case (ctl_reg)
            CTL_RUN: begin
                if (accept) begin
                    ctx_next     = step_ctx;
                    total_next   = step_total;
                    osc_len_next = step_osc;
                    if (step.dispatch) begin
                        ctl_next      = CTL_DISPATCH;
                        emit_idx_next = '0;
                    end else if (step.n_events != 2'd0) begin
                        load_out  = 1'b1;
                        load_last = (step.n_events == 2'd1);
                        if (step.n_events == 2'd2) begin
                            load_sec = 1'b1;
                            ctl_next = CTL_SECOND;
                        end
                    end
                end
            end
            CTL_SECOND: begin
                if (slot_free) begin
                    load_out  = 1'b1;
                    load_ev   = sec_ev_reg;
                    load_last = 1'b1;
                    ctl_next  = CTL_RUN;
                end
            end
            CTL_DISPATCH: begin
                if (slot_free) begin
                    load_out  = 1'b1;
                    load_ev   = csi_ev;
                    load_last = emit_is_last;
                    if (emit_is_last) begin
                        ctl_next = CTL_RUN;
                    end else begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                ctl_next = CTL_RUN;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctl_reg       <= CTL_RUN;
            ctx_reg       <= CTX_RESET;
            total_reg     <= '0;
            osc_len_reg   <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ctl_reg       <= ctl_next;
            ctx_reg       <= ctx_next;
            total_reg     <= total_next;
            osc_len_reg   <= osc_len_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // store writes only happen on separators, outside dispatch; the read port samples
    // every cycle, but its data is only used during dispatch, when no write can occur
    always_ff @(posedge clk) begin
        if (load_out) begin
            out_ev_reg   <= load_ev;
            out_last_reg <= load_last;
        end
        if (load_sec) begin
            sec_ev_reg <= step.ev1;
        end
        if (accept && step.dispatch) begin
            final_reg <= stream.byte_req;
        end
        if (accept && step.mem_we) begin
            param_mem[step_waddr] <= ctx_reg.cur_param;
        end
        mem_q_reg <= param_mem[emit_idx_next];
    end

    assign events.valid             = out_valid_reg;
    assign events.kind              = out_ev_reg.kind;
    assign events.code              = out_ev_reg.code;
    assign events.private_marker    = out_ev_reg.private_marker;
    assign events.intermediate_byte = out_ev_reg.intermediate_byte;
    assign events.param_index       = out_ev_reg.param_index;
    assign events.param_value       = out_ev_reg.param_value;
    assign events.param_count       = out_ev_reg.param_count;
    assign events.string_length     = out_ev_reg.string_length;
    assign events.last              = out_last_reg;

`ifndef SYNTHESIS
    // a csi final always starts a dispatch in the next cycle
    a_dispatch_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step.dispatch) |=> (ctl_reg == CTL_DISPATCH))
        else $error("csi final did not start a dispatch");

    // the dispatch index never runs past the last event of the sequence
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == CTL_DISPATCH) |-> (TOT_W'(emit_idx_reg) <= emit_last_idx))
        else $error("dispatch index past the parameter count");

    // while the second event waits, the first one sits in the output register
    a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == CTL_SECOND) |-> out_valid_reg)
        else $error("second event pending without a first one");
`endif

endmodule
